// ===== sv/mtne_pkg.sv =====
// Shared types, widths and result codes of the MIDI track note extractor.
`default_nettype none
package mtne_pkg;

    localparam int MAX_CHUNK_BYTES_DEF = 65536;
    localparam int TIME_BITS_DEF       = 28;

    localparam int BYTE_W = 8;
    localparam int KIND_W = 2;
    localparam int TIME_W = 28;
    localparam int NOTE_W = 7;

    localparam logic [KIND_W-1:0] KIND_NOTE_ON   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_NOTE_OFF  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_TRACK_END = 2'd2;
    localparam logic [KIND_W-1:0] KIND_TOO_LONG  = 2'd3;

    typedef logic [TIME_W-1:0] t_time;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        t_time             event_time;
        logic [NOTE_W-1:0] note_number;
    } t_result;

    // results caused by one input byte; r1 only used when two is set
    typedef struct packed {
        logic    two;
        t_result r0;
        t_result r1;
    } t_group;

    typedef struct packed {
        logic   valid;
        t_group group;
    } t_push;

    typedef struct packed {
        logic halted;
    } t_front_stat;

endpackage
`default_nettype wire

// ===== sv/mtne_if.sv =====
// Stream interfaces for the byte input and the result output.
`default_nettype none
interface mtne_in_if;
    logic                      valid;
    logic                      ready;
    logic [mtne_pkg::BYTE_W-1:0] in_byte;

    modport source(output valid, output in_byte, input ready);
    modport sink(input valid, input in_byte, output ready);
endinterface

interface mtne_out_if;
    logic                      valid;
    logic                      ready;
    logic [mtne_pkg::KIND_W-1:0] kind;
    logic [mtne_pkg::TIME_W-1:0] event_time;
    logic [mtne_pkg::NOTE_W-1:0] note_number;
    logic                      last_of_run;

    modport source(output valid, output kind, output event_time, output note_number,
                   output last_of_run, input ready);
    modport sink(input valid, input kind, input event_time, input note_number,
                 input last_of_run, output ready);
endinterface
`default_nettype wire

// ===== sv/mtne_front.sv =====
// Front end: chunk and track event parser, one byte per transfer.
`default_nettype none
module mtne_front #(
    parameter int MAX_CHUNK_BYTES = mtne_pkg::MAX_CHUNK_BYTES_DEF,
    parameter int TIME_BITS       = mtne_pkg::TIME_BITS_DEF
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    mtne_in_if.sink              i_in,
    input  wire logic            i_full,
    output mtne_pkg::t_push      o_push,
    output mtne_pkg::t_front_stat o_stat
);

    localparam int CW = $clog2(MAX_CHUNK_BYTES + 1);

    localparam logic [3:0] PH_TYPE      = 4'd0;
    localparam logic [3:0] PH_LEN       = 4'd1;
    localparam logic [3:0] PH_SKIP      = 4'd2;
    localparam logic [3:0] PH_DELTA     = 4'd3;
    localparam logic [3:0] PH_STATUS    = 4'd4;
    localparam logic [3:0] PH_META_TYPE = 4'd5;
    localparam logic [3:0] PH_META_LEN  = 4'd6;
    localparam logic [3:0] PH_META_DATA = 4'd7;
    localparam logic [3:0] PH_DATA1     = 4'd8;
    localparam logic [3:0] PH_DATA2     = 4'd9;
    localparam logic [3:0] PH_HALT      = 4'd10;

    localparam logic [3:0] ST_NOTE_OFF = 4'h8;
    localparam logic [3:0] ST_NOTE_ON  = 4'h9;
    localparam logic [3:0] ST_CTRL     = 4'hB;
    localparam logic [3:0] ST_PROG     = 4'hC;
    localparam logic [7:0] ST_META     = 8'hFF;

    function automatic logic [7:0] f_tag(input logic [1:0] idx);
        logic [7:0] t;
        case (idx)
            2'd0:    t = 8'h4D;
            2'd1:    t = 8'h54;
            2'd2:    t = 8'h68;
            default: t = 8'h64;
        endcase
        return t;
    endfunction

    function automatic logic [3:0] f_after(input logic [7:0] s);
        logic [3:0] p;
        if (s == ST_META) begin
            p = PH_META_TYPE;
        end else if (s[7:4] == ST_NOTE_OFF || s[7:4] == ST_NOTE_ON ||
                     s[7:4] == ST_CTRL || s[7:4] == ST_PROG) begin
            p = PH_DATA1;
        end else begin
            p = PH_DELTA;
        end
        return p;
    endfunction

    function automatic mtne_pkg::t_result f_res(input logic [mtne_pkg::KIND_W-1:0] k,
                                                input mtne_pkg::t_time t,
                                                input logic [mtne_pkg::NOTE_W-1:0] n);
        mtne_pkg::t_result r;
        r.kind        = k;
        r.event_time  = t;
        r.note_number = n;
        return r;
    endfunction

    logic [3:0]           r_phase, n_phase;
    logic [1:0]           r_bc, n_bc;
    logic                 r_mthd, n_mthd;
    logic [31:0]          r_len, n_len;
    logic [CW-1:0]        r_left, n_left;
    logic [7:0]           r_rs, n_rs;
    logic [TIME_BITS-1:0] r_vlq, n_vlq;
    logic [TIME_BITS-1:0] r_time, n_time;
    logic                 r_pend, n_pend;
    logic [TIME_BITS-1:0] r_ptime, n_ptime;
    logic [6:0]           r_cur, n_cur;
    logic [6:0]           r_dnote, n_dnote;
    logic [27:0]          r_meta, n_meta;

    logic                 w_acc;
    logic [7:0]           w_b;
    logic [3:0]           w_eph;
    logic                 w_done;
    logic [31:0]          w_len;
    logic [TIME_BITS-1:0] w_vlq;
    logic [27:0]          w_meta;
    mtne_pkg::t_result    w_e0, w_e1;
    logic [1:0]           w_ecnt;

    assign i_in.ready = !i_full;
    assign w_acc      = i_in.valid && !i_full;
    assign w_b        = i_in.in_byte;

    always_comb begin
        n_phase = r_phase;
        n_bc    = r_bc;
        n_mthd  = r_mthd;
        n_len   = r_len;
        n_left  = r_left;
        n_rs    = r_rs;
        n_vlq   = r_vlq;
        n_time  = r_time;
        n_pend  = r_pend;
        n_ptime = r_ptime;
        n_cur   = r_cur;
        n_dnote = r_dnote;
        n_meta  = r_meta;
        w_eph   = r_phase;
        w_done  = 1'b0;
        w_len   = {r_len[23:0], w_b};
        w_vlq   = {r_vlq[TIME_BITS-8:0], w_b[6:0]};
        w_meta  = {r_meta[20:0], w_b[6:0]};
        w_e0    = '0;
        w_e1    = '0;
        w_ecnt  = 2'd0;

        case (r_phase)
            PH_HALT: begin
            end
            PH_TYPE: begin
                n_mthd = (r_bc == 2'd0) ? (w_b == f_tag(r_bc))
                                        : (r_mthd && (w_b == f_tag(r_bc)));
                n_bc = r_bc + 2'd1;
                if (r_bc == 2'd3) begin
                    n_len   = '0;
                    n_phase = PH_LEN;
                end
            end
            PH_LEN: begin
                n_len = w_len;
                n_bc  = r_bc + 2'd1;
                if (r_bc == 2'd3) begin
                    if (w_len > 32'(MAX_CHUNK_BYTES)) begin
                        w_e0    = f_res(mtne_pkg::KIND_TOO_LONG, '0, '0);
                        w_ecnt  = 2'd1;
                        n_phase = PH_HALT;
                    end else begin
                        n_left = w_len[CW-1:0];
                        if (r_mthd) begin
                            n_phase = (w_len == 32'd0) ? PH_TYPE : PH_SKIP;
                        end else begin
                            n_time  = '0;
                            n_pend  = 1'b0;
                            n_ptime = '0;
                            n_vlq   = '0;
                            n_phase = PH_DELTA;
                            if (w_len == 32'd0) begin
                                w_e0    = f_res(mtne_pkg::KIND_TRACK_END, '0, '0);
                                w_ecnt  = 2'd1;
                                n_phase = PH_TYPE;
                                n_bc    = 2'd0;
                            end
                        end
                    end
                end
            end
            PH_SKIP: begin
                n_left = r_left - CW'(1);
                if (n_left == '0) begin
                    n_phase = PH_TYPE;
                end
            end
            default: begin
                w_done = 1'b0;
                if (r_phase == PH_STATUS) begin
                    if (w_b[7]) begin
                        n_rs    = w_b;
                        n_phase = f_after(w_b);
                        w_done  = 1'b1;
                    end else begin
                        w_eph = f_after(r_rs);
                    end
                end
                if (!w_done) begin
                    case (w_eph)
                        PH_DELTA: begin
                            if (w_b[7]) begin
                                n_vlq = w_vlq;
                            end else begin
                                n_vlq = '0;
                                if (w_vlq != '0 && r_pend) begin
                                    w_e0   = f_res(mtne_pkg::KIND_NOTE_OFF,
                                                   mtne_pkg::t_time'(r_ptime), '0);
                                    w_ecnt = 2'd1;
                                    n_pend = 1'b0;
                                end
                                n_time  = r_time + w_vlq;
                                n_phase = PH_STATUS;
                            end
                        end
                        PH_META_TYPE: begin
                            n_meta  = '0;
                            n_phase = PH_META_LEN;
                        end
                        PH_META_LEN: begin
                            n_meta = w_meta;
                            if (!w_b[7]) begin
                                n_phase = (w_meta != '0) ? PH_META_DATA : PH_DELTA;
                            end
                        end
                        PH_META_DATA: begin
                            n_meta = r_meta - 28'd1;
                            if (n_meta == '0) begin
                                n_phase = PH_DELTA;
                            end
                        end
                        PH_DATA1: begin
                            if (r_rs[7:4] == ST_PROG) begin
                                n_phase = PH_DELTA;
                            end else begin
                                n_dnote = w_b[6:0];
                                n_phase = PH_DATA2;
                            end
                        end
                        PH_DATA2: begin
                            if (r_rs[7:4] == ST_NOTE_OFF) begin
                                if (r_dnote == r_cur) begin
                                    n_pend  = 1'b1;
                                    n_ptime = r_time;
                                end
                            end else if (r_rs[7:4] == ST_NOTE_ON) begin
                                n_cur  = r_dnote;
                                n_pend = 1'b0;
                                w_e0   = f_res(mtne_pkg::KIND_NOTE_ON,
                                               mtne_pkg::t_time'(r_time), r_dnote);
                                w_ecnt = 2'd1;
                            end
                            n_phase = PH_DELTA;
                        end
                        default: begin
                            n_phase = PH_DELTA;
                        end
                    endcase
                end

                n_left = (r_left != '0) ? (r_left - CW'(1)) : r_left;
                if (n_left == '0) begin
                    // chunk end: flush pending off, then track end
                    if (n_pend) begin
                        w_e0   = f_res(mtne_pkg::KIND_NOTE_OFF,
                                       mtne_pkg::t_time'(n_ptime), '0);
                        w_ecnt = 2'd1;
                        n_pend = 1'b0;
                    end
                    if (w_ecnt == 2'd0) begin
                        w_e0 = f_res(mtne_pkg::KIND_TRACK_END, '0, '0);
                    end else begin
                        w_e1 = f_res(mtne_pkg::KIND_TRACK_END, '0, '0);
                    end
                    w_ecnt  = w_ecnt + 2'd1;
                    n_phase = PH_TYPE;
                    n_bc    = 2'd0;
                end
            end
        endcase
    end

    always_comb begin
        o_push.valid    = w_acc && (w_ecnt != 2'd0);
        o_push.group.two = (w_ecnt == 2'd2);
        o_push.group.r0 = w_e0;
        o_push.group.r1 = w_e1;
        o_stat.halted   = (r_phase == PH_HALT);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_TYPE;
            r_bc    <= '0;
            r_mthd  <= 1'b1;
            r_len   <= '0;
            r_left  <= '0;
            r_rs    <= '0;
            r_vlq   <= '0;
            r_time  <= '0;
            r_pend  <= 1'b0;
            r_ptime <= '0;
            r_cur   <= '0;
            r_dnote <= '0;
            r_meta  <= '0;
        end else if (w_acc) begin
            r_phase <= n_phase;
            r_bc    <= n_bc;
            r_mthd  <= n_mthd;
            r_len   <= n_len;
            r_left  <= n_left;
            r_rs    <= n_rs;
            r_vlq   <= n_vlq;
            r_time  <= n_time;
            r_pend  <= n_pend;
            r_ptime <= n_ptime;
            r_cur   <= n_cur;
            r_dnote <= n_dnote;
            r_meta  <= n_meta;
        end
    end

endmodule
`default_nettype wire

// ===== sv/mtne_queue.sv =====
// Result-group queue between parser and output serializer.
`default_nettype none
module mtne_queue (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire mtne_pkg::t_push  i_push,
    input  wire logic             i_pop,
    output logic                  o_full,
    output logic                  o_head_valid,
    output mtne_pkg::t_group      o_head
);

    localparam int DEPTH = 4;
    localparam int AW    = $clog2(DEPTH);

    mtne_pkg::t_group r_mem [DEPTH];
    logic [AW-1:0]    r_wr, r_rd;
    logic [AW:0]      r_cnt;
    logic             w_wr_en, w_rd_en;

    assign o_full       = (r_cnt == (AW + 1)'(DEPTH));
    assign o_head_valid = (r_cnt != '0);
    assign o_head       = r_mem[r_rd];
    assign w_wr_en      = i_push.valid && !o_full;
    assign w_rd_en      = i_pop && o_head_valid;

    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem[r_wr] <= i_push.group;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_wr_en) begin
                r_wr <= r_wr + AW'(1);
            end
            if (w_rd_en) begin
                r_rd <= r_rd + AW'(1);
            end
            case ({w_wr_en, w_rd_en})
                2'b10:   r_cnt <= r_cnt + (AW + 1)'(1);
                2'b01:   r_cnt <= r_cnt - (AW + 1)'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule
`default_nettype wire

// ===== sv/mtne_back.sv =====
// Back end: serializes queued result groups onto the output stream.
`default_nettype none
module mtne_back (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_head_valid,
    input  wire mtne_pkg::t_group i_head,
    output logic                  o_pop,
    mtne_out_if.source            o_out
);

    logic              r_valid;
    logic              r_idx;
    mtne_pkg::t_group  r_group;
    mtne_pkg::t_result w_sel;
    logic              w_last, w_xfer, w_load;

    assign w_sel  = r_idx ? r_group.r1 : r_group.r0;
    assign w_last = r_idx || !r_group.two;
    assign w_xfer = r_valid && o_out.ready;
    assign w_load = !r_valid || (w_xfer && w_last);
    assign o_pop  = i_head_valid && w_load;

    assign o_out.valid       = r_valid;
    assign o_out.kind        = w_sel.kind;
    assign o_out.event_time  = w_sel.event_time;
    assign o_out.note_number = w_sel.note_number;
    assign o_out.last_of_run = w_last;

    always_ff @(posedge i_clk) begin
        if (w_load && i_head_valid) begin
            r_group <= i_head;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= 1'b0;
        end else if (w_xfer && !w_last) begin
            r_idx <= 1'b1;
        end else if (w_load) begin
            r_valid <= i_head_valid;
            r_idx   <= 1'b0;
        end
    end

endmodule
`default_nettype wire

// ===== sv/midi_track_note_extractor.sv =====
// Top level of the MIDI track note extractor: parser, result queue, serializer.
//
//   channel  dir  payload                                        transfer
//   i_in     in   in_byte[7:0]                                   valid & ready
//   o_out    out  kind[1:0] event_time[27:0] note_number[6:0]
//                 last_of_run                                    valid & ready
//
// One input byte per cycle; the parser decodes each byte as it is accepted.
// A byte yields zero to two results; results leave one per cycle, so a run of
// two-result bytes is paced by the output port, absorbed by a 4-entry queue.
// Input ready drops only while that queue is full; output stalls back up into it.
// Synchronous active-low reset returns the parser to the chunk type field.
// A chunk length above the limit reports once, then all bytes are dropped.
`default_nettype none
module midi_track_note_extractor #(
    parameter int MAX_CHUNK_BYTES = mtne_pkg::MAX_CHUNK_BYTES_DEF,
    parameter int TIME_BITS       = mtne_pkg::TIME_BITS_DEF
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    mtne_in_if.sink   i_in,
    mtne_out_if.source o_out
);

    mtne_pkg::t_push       w_push;
    mtne_pkg::t_front_stat w_stat;
    mtne_pkg::t_group      w_head;
    logic                  w_full, w_head_valid, w_pop;

    mtne_front #(
        .MAX_CHUNK_BYTES(MAX_CHUNK_BYTES),
        .TIME_BITS      (TIME_BITS)
    ) u_front (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (i_in),
        .i_full (w_full),
        .o_push (w_push),
        .o_stat (w_stat)
    );

    mtne_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (w_push),
        .i_pop       (w_pop),
        .o_full      (w_full),
        .o_head_valid(w_head_valid),
        .o_head      (w_head)
    );

    mtne_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head_valid(w_head_valid),
        .i_head      (w_head),
        .o_pop       (w_pop),
        .o_out       (o_out)
    );

`ifndef NO_ASSERTIONS
    a_halt_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_stat.halted |=> w_stat.halted)
        else $error("halt state left without reset");

    a_halt_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_stat.halted |-> !w_push.valid)
        else $error("results queued after halt");

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push.valid |-> !w_full)
        else $error("push into full queue");

    a_second_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.ready && !o_out.last_of_run) |=> o_out.valid)
        else $error("second result of a byte missing");
`endif

endmodule
`default_nettype wire

// ===== dv/tb_top.sv =====
// Testbench for the MIDI track note extractor: random MIDI byte streams checked against a parser model.
`timescale 1ns / 100ps
module tb_top;

    localparam logic [31:0] TAG_MTHD    = 32'h4D54_6864;
    localparam logic [31:0] TAG_MTRK    = 32'h4D54_726B;
    localparam logic [31:0] MAX_CHUNK   = 32'(mtne_pkg::MAX_CHUNK_BYTES_DEF);
    localparam logic [3:0]  HI_NOTE_OFF = 4'h8;
    localparam logic [3:0]  HI_NOTE_ON  = 4'h9;
    localparam logic [3:0]  HI_POLY     = 4'hA;
    localparam logic [3:0]  HI_CONTROL  = 4'hB;
    localparam logic [3:0]  HI_PROGRAM  = 4'hC;
    localparam logic [3:0]  HI_PRESSURE = 4'hD;
    localparam logic [3:0]  HI_BEND     = 4'hE;
    localparam logic [7:0]  STATUS_SYS  = 8'hF0;
    localparam logic [7:0]  STATUS_META = 8'hFF;
    localparam int HOLD_CYCLES = 400;
    localparam int QUIET_LIMIT = 3000;
    localparam int PHASE_BYTES = 500;

    typedef enum logic [3:0] {
        PARSE_TYPE, PARSE_LEN, PARSE_SKIP, PARSE_DELTA, PARSE_STATUS, PARSE_META_TYPE,
        PARSE_META_LEN, PARSE_META_DATA, PARSE_DATA1, PARSE_DATA2, PARSE_HALT
    } t_parse;

    typedef struct packed {
        mtne_pkg::t_result res;
        logic              last;
    } t_note_event;

    class t_note_tracker;
        t_note_event       pending[$];
        mtne_pkg::t_result step_out[$];
        int                mismatches;
        t_parse            phase;
        logic [1:0]        hdr_idx;
        bit                is_mthd;
        logic [31:0]       len_acc;
        logic [16:0]       bytes_left;
        logic [7:0]        run_status;
        mtne_pkg::t_time   delta_acc;
        mtne_pkg::t_time   now_time;
        mtne_pkg::t_time   off_stamp;
        bit                off_armed;
        logic [6:0]        cur_note;
        logic [6:0]        data_note;
        logic [27:0]       meta_left;

        function new();
            phase      = PARSE_TYPE;
            hdr_idx    = 0;
            is_mthd    = 1;
            len_acc    = 0;
            bytes_left = 0;
            run_status = 0;
            delta_acc  = 0;
            now_time   = 0;
            off_stamp  = 0;
            off_armed  = 0;
            cur_note   = 0;
            data_note  = 0;
            meta_left  = 0;
            mismatches = 0;
        endfunction

        function bit busy();
            return pending.size() != 0;
        endfunction

        function void put(logic [mtne_pkg::KIND_W-1:0] kind, mtne_pkg::t_time tm,
                          logic [mtne_pkg::NOTE_W-1:0] note);
            mtne_pkg::t_result r;
            if (step_out.size() >= 2) return;
            r.kind        = kind;
            r.event_time  = tm;
            r.note_number = note;
            step_out.push_back(r);
        endfunction

        function t_parse status_phase();
            if (run_status == STATUS_META) return PARSE_META_TYPE;
            if (run_status[7:4] inside {HI_NOTE_OFF, HI_NOTE_ON, HI_CONTROL, HI_PROGRAM})
                return PARSE_DATA1;
            return PARSE_DELTA;
        endfunction

        function void close_chunk();
            if (off_armed) begin
                put(mtne_pkg::KIND_NOTE_OFF, off_stamp, '0);
                off_armed = 0;
            end
            put(mtne_pkg::KIND_TRACK_END, '0, '0);
            phase   = PARSE_TYPE;
            hdr_idx = 0;
        endfunction

        function void open_chunk();
            if (len_acc > MAX_CHUNK) begin
                put(mtne_pkg::KIND_TOO_LONG, '0, '0);
                phase = PARSE_HALT;
                return;
            end
            bytes_left = len_acc[16:0];
            if (is_mthd) begin
                phase = (len_acc == 0) ? PARSE_TYPE : PARSE_SKIP;
                return;
            end
            now_time  = 0;
            off_armed = 0;
            off_stamp = 0;
            delta_acc = 0;
            phase     = PARSE_DELTA;
            if (len_acc == 0) close_chunk();
        endfunction

        function void track_byte(logic [7:0] b);
            bit              again;
            mtne_pkg::t_time d;
            do begin
                again = 0;
                case (phase)
                    PARSE_DELTA: begin
                        delta_acc = {delta_acc[mtne_pkg::TIME_W-8:0], b[6:0]};
                        if (!b[7]) begin
                            d         = delta_acc;
                            delta_acc = 0;
                            if (d != 0 && off_armed) begin
                                put(mtne_pkg::KIND_NOTE_OFF, off_stamp, '0);
                                off_armed = 0;
                            end
                            now_time = now_time + d;
                            phase    = PARSE_STATUS;
                        end
                    end
                    PARSE_STATUS: begin
                        if (b[7]) begin
                            run_status = b;
                            phase      = status_phase();
                        end else begin
                            // data byte under running status: parse it again
                            phase = status_phase();
                            again = 1;
                        end
                    end
                    PARSE_META_TYPE: begin
                        meta_left = 0;
                        phase     = PARSE_META_LEN;
                    end
                    PARSE_META_LEN: begin
                        meta_left = {meta_left[20:0], b[6:0]};
                        if (!b[7]) phase = (meta_left != 0) ? PARSE_META_DATA : PARSE_DELTA;
                    end
                    PARSE_META_DATA: begin
                        meta_left = meta_left - 28'd1;
                        if (meta_left == 0) phase = PARSE_DELTA;
                    end
                    PARSE_DATA1: begin
                        if (run_status[7:4] == HI_PROGRAM) begin
                            phase = PARSE_DELTA;
                        end else begin
                            data_note = b[6:0];
                            phase     = PARSE_DATA2;
                        end
                    end
                    PARSE_DATA2: begin
                        if (run_status[7:4] == HI_NOTE_OFF) begin
                            if (data_note == cur_note) begin
                                off_armed = 1;
                                off_stamp = now_time;
                            end
                        end else if (run_status[7:4] == HI_NOTE_ON) begin
                            cur_note  = data_note;
                            off_armed = 0;
                            put(mtne_pkg::KIND_NOTE_ON, now_time, cur_note);
                        end
                        phase = PARSE_DELTA;
                    end
                    default: phase = PARSE_DELTA;
                endcase
            end while (again);
        endfunction

        function void parse_byte(logic [7:0] b);
            bit          hit;
            logic [7:0]  tag_byte;
            t_note_event e;
            step_out.delete();
            case (phase)
                PARSE_HALT: ;
                PARSE_TYPE: begin
                    tag_byte = 8'(TAG_MTHD >> (8 * (3 - int'(hdr_idx))));
                    hit      = (b == tag_byte);
                    is_mthd  = (hdr_idx == 0) ? hit : (is_mthd && hit);
                    hdr_idx  = hdr_idx + 2'd1;
                    if (hdr_idx == 0) begin
                        len_acc = 0;
                        phase   = PARSE_LEN;
                    end
                end
                PARSE_LEN: begin
                    len_acc = {len_acc[23:0], b};
                    hdr_idx = hdr_idx + 2'd1;
                    if (hdr_idx == 0) open_chunk();
                end
                PARSE_SKIP: begin
                    bytes_left = bytes_left - 17'd1;
                    if (bytes_left == 0) phase = PARSE_TYPE;
                end
                default: begin
                    track_byte(b);
                    if (bytes_left != 0) bytes_left = bytes_left - 17'd1;
                    if (bytes_left == 0) close_chunk();
                end
            endcase
            foreach (step_out[i]) begin
                e.res  = step_out[i];
                e.last = (i == step_out.size() - 1);
                pending.push_back(e);
            end
        endfunction

        function void report(string what, t_note_event want, t_note_event got);
            mismatches++;
            if (mismatches <= 10)
                $display("tb_top: %s at %0t: want kind %0d time %0d note %0d last %0d, %s",
                         what, $time, want.res.kind, want.res.event_time,
                         want.res.note_number, want.last,
                         $sformatf("got kind %0d time %0d note %0d last %0d",
                                   got.res.kind, got.res.event_time,
                                   got.res.note_number, got.last));
        endfunction

        function void match_event(t_note_event got);
            t_note_event want;
            if (pending.size() == 0) begin
                want = '0;
                report("result with nothing pending", want, got);
                return;
            end
            want = pending.pop_front();
            if (want.res.kind !== got.res.kind || want.res.event_time !== got.res.event_time ||
                want.res.note_number !== got.res.note_number || want.last !== got.last)
                report("mismatch", want, got);
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;

    mtne_in_if  in_if();
    mtne_out_if out_if();

    midi_track_note_extractor dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    t_note_tracker tracker;
    int         tx_idle_pct = 12;
    int         rx_idle_pct = 86;
    int         hold_seq    = 0;
    int         hold_seen   = 0;
    int         hold_left   = 0;
    int         quiet_cycles = 0;
    int         bytes_sent  = 0;
    logic [7:0] byte_q[$];
    logic [7:0] body_q[$];
    logic [7:0] gen_status = 8'h00;
    logic [6:0] gen_note   = 7'd60;

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        t_note_event got;
        if (in_if.valid && in_if.ready) tracker.parse_byte(in_if.in_byte);
        if (out_if.valid && out_if.ready) begin
            got.res.kind        = out_if.kind;
            got.res.event_time  = out_if.event_time;
            got.res.note_number = out_if.note_number;
            got.last            = out_if.last_of_run;
            tracker.match_event(got);
        end
    end

    always @(posedge i_clk) begin
        if (hold_seq != hold_seen) begin
            hold_seen    <= hold_seq;
            hold_left    <= HOLD_CYCLES;
            out_if.ready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left    <= hold_left - 1;
            out_if.ready <= 1'b0;
        end else begin
            out_if.ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("tb_top: errors");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic void push_word(logic [31:0] w);
        for (int i = 3; i >= 0; i--) byte_q.push_back(w[8*i +: 8]);
    endfunction

    function automatic void put_vlq(logic [27:0] v);
        int n;
        n = 1;
        while (n < 4 && (v >> (7 * n)) != 0) n++;
        for (int i = n - 1; i >= 0; i--) body_q.push_back({i != 0, v[7*i +: 7]});
    endfunction

    function automatic void finish_chunk(logic [31:0] tag, int len);
        push_word(tag);
        push_word(32'(len));
        for (int i = 0; i < len; i++) byte_q.push_back(body_q[i]);
        body_q.delete();
    endfunction

    function automatic void gen_delta();
        int r;
        r = $urandom_range(99);
        if (r < 45) begin
            put_vlq('0);
        end else if (r < 72) begin
            put_vlq(28'($urandom_range(1, 127)));
        end else if (r < 85) begin
            put_vlq(28'($urandom_range(128, 16383)));
        end else if (r < 91) begin
            put_vlq(28'($urandom_range(16384, 28'hFFF_FFFF)));
        end else if (r < 95) begin
            put_vlq(28'hFFF_FFFF);
        end else if (r < 98) begin
            body_q.push_back(8'h80);
            body_q.push_back(8'h80 | 8'($urandom_range(127)));
            body_q.push_back(8'($urandom_range(127)));
        end else begin
            // five-byte quantity overflows the accumulator
            repeat (4) body_q.push_back(8'h80 | 8'($urandom_range(127)));
            body_q.push_back(8'($urandom_range(127)));
        end
    endfunction

    function automatic logic [7:0] pick_note();
        int         r;
        logic [6:0] n;
        r = $urandom_range(99);
        if (r < 55) n = gen_note;
        else if (r < 85) n = 7'(60 + $urandom_range(3));
        else n = 7'($urandom_range(127));
        return {$urandom_range(99) < 10, n};
    endfunction

    function automatic logic [7:0] pick_data();
        return ($urandom_range(99) < 10) ? 8'($urandom_range(255)) : 8'($urandom_range(127));
    endfunction

    function automatic void put_channel(logic [3:0] hi);
        if (gen_status[7:4] != hi || $urandom_range(1) == 0) begin
            gen_status = {hi, 4'($urandom_range(15))};
            body_q.push_back(gen_status);
        end
    endfunction

    function automatic void gen_event();
        int         r;
        int         n;
        logic [7:0] note;
        gen_delta();
        r = $urandom_range(99);
        if (r < 30) begin
            put_channel(HI_NOTE_ON);
            note     = pick_note();
            gen_note = note[6:0];
            body_q.push_back(note);
            body_q.push_back(($urandom_range(99) < 20) ? 8'h00 : pick_data());
        end else if (r < 48) begin
            put_channel(HI_NOTE_OFF);
            note = ($urandom_range(99) < 70) ? {1'b0, gen_note} : pick_note();
            body_q.push_back(note);
            body_q.push_back(pick_data());
        end else if (r < 56) begin
            put_channel(HI_CONTROL);
            body_q.push_back(pick_data());
            body_q.push_back(pick_data());
        end else if (r < 62) begin
            put_channel(HI_PROGRAM);
            body_q.push_back(pick_data());
        end else if (r < 72) begin
            gen_status = STATUS_META;
            body_q.push_back(STATUS_META);
            body_q.push_back(8'($urandom_range(127)));
            r = $urandom_range(99);
            n = $urandom_range(5);
            if (r < 85) begin
                put_vlq(28'(n));
            end else if (r < 95) begin
                body_q.push_back(8'h80);
                put_vlq(28'(n));
            end else begin
                // length far beyond the chunk; the chunk end cuts it
                repeat (4) body_q.push_back(8'hFF);
                body_q.push_back(8'h7F);
                n = 0;
            end
            repeat (n) body_q.push_back(8'($urandom_range(255)));
        end else if (r < 80) begin
            case ($urandom_range(2))
                0:       gen_status = {HI_POLY, 4'($urandom_range(15))};
                1:       gen_status = {$urandom_range(1) ? HI_PRESSURE : HI_BEND,
                                       4'($urandom_range(15))};
                default: gen_status = STATUS_SYS + 8'($urandom_range(14));
            endcase
            body_q.push_back(gen_status);
            repeat ($urandom_range(2)) body_q.push_back(8'($urandom_range(127)));
        end else if (r < 90) begin
            body_q.push_back(pick_note());
            body_q.push_back(pick_data());
        end else begin
            repeat ($urandom_range(1, 3)) body_q.push_back(8'($urandom_range(255)));
        end
    endfunction

    task automatic send_byte(logic [7:0] b);
        while ($urandom_range(99) < tx_idle_pct) begin
            in_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_if.valid   <= 1'b1;
        in_if.in_byte <= b;
        do @(posedge i_clk); while (!in_if.ready);
        bytes_sent++;
    endtask

    task automatic send_queue();
        foreach (byte_q[i]) send_byte(byte_q[i]);
        byte_q.delete();
    endtask

    task automatic send_random_chunk();
        int          r;
        int          n;
        int          len;
        logic [31:0] tag;
        r = $urandom_range(99);
        if (r < 10) begin
            n = ($urandom_range(99) < 60) ? 6 : $urandom_range(12);
            repeat (n) body_q.push_back(8'($urandom_range(255)));
            finish_chunk(TAG_MTHD, n);
        end else begin
            r = $urandom_range(99);
            if (r < 78) tag = TAG_MTRK;
            else if (r < 84) tag = {TAG_MTHD[31:8], 8'($urandom_range(255))};
            else if (r < 90) tag = {8'h4D, 24'($urandom())};
            else if (r < 95) tag = TAG_MTHD ^ (32'h1 << $urandom_range(31));
            else tag = $urandom();
            r = $urandom_range(99);
            if (r < 4) n = 0;
            else if (r < 90) n = $urandom_range(1, 10);
            else n = $urandom_range(20, 40);
            repeat (n) gen_event();
            len = body_q.size();
            // cut the chunk short so an event is left unfinished
            if (len != 0 && $urandom_range(99) < 15) len = $urandom_range(len - 1);
            finish_chunk(tag, len);
        end
        send_queue();
    endtask

    initial begin
        int          target;
        logic [31:0] big_len;
        tracker       = new();
        i_rst_n       = 1'b0;
        in_if.valid   = 1'b0;
        in_if.in_byte = 8'h00;
        out_if.ready  = 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        push_word(TAG_MTHD);
        push_word('0);
        push_word(TAG_MTRK);
        push_word('0);
        body_q = {8'h00, 8'h05, 8'h90, 8'hBC, 8'h40, 8'h83, 8'h00, 8'h80, 8'h3C, 8'h7F, 8'h00};
        finish_chunk(TAG_MTRK, 11);
        send_queue();

        target = bytes_sent;
        for (int ph = 0; ph < 3; ph++) begin
            tx_idle_pct = (ph == 0) ? 12 : (ph == 1) ? 86 : 0;
            rx_idle_pct = (ph == 0) ? 86 : (ph == 1) ? 12 : 0;
            if (ph == 2) hold_seq++;
            target += PHASE_BYTES;
            while (bytes_sent < target) send_random_chunk();
        end

        case ($urandom_range(2))
            0:       big_len = MAX_CHUNK + 32'd1;
            1:       big_len = 32'hFFFF_FFFF;
            default: big_len = $urandom_range(32'h7FFF_FFFF, MAX_CHUNK + 32'd1);
        endcase
        push_word($urandom_range(1) ? TAG_MTHD : TAG_MTRK);
        push_word(big_len);
        repeat (6) byte_q.push_back(8'($urandom_range(255)));
        send_queue();
        in_if.valid <= 1'b0;

        while (tracker.busy()) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        if (tracker.mismatches == 0 && !tracker.busy())
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end
endmodule
